// ===== rtl/core/rrip_pkg.sv =====
// Shared types and constants for the RRIP key set.
// Used by rrip_cell and the top level; no dependencies.
package rrip_pkg;

  localparam int unsigned LEVEL_BITS   = 3;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned CAP_BITS     = 7;
  localparam int unsigned DEF_ENTRIES  = 64;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [LEVEL_BITS-1:0] TOP_LEVEL    = {LEVEL_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0] INSERT_LEVEL = TOP_LEVEL - 1'b1;
  localparam logic [CAP_BITS-1:0]   CAP_RESET    = CAP_BITS'(64);

  localparam logic [APB_ADDR_W-1:0] REG_CAPACITY = '0;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic                  vld;
    logic [KEY_BITS-1:0]   key;
    logic [LEVEL_BITS-1:0] lvl;
  } entry_t;

  typedef struct packed {
    logic                  upd;
    logic [LEVEL_BITS-1:0] raise;
  } ctrl_t;

endpackage

// ===== rtl/core/rrip_cell.sv =====
// One entry of the age-ordered RRIP chain: holds a key and its level.
// Depends on rrip_pkg.
module rrip_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrip_pkg::ctrl_t               ctrl_i,
  input  logic                          take_i,
  input  rrip_pkg::entry_t              prev_i,
  input  logic [rrip_pkg::KEY_BITS-1:0] key_i,
  output rrip_pkg::entry_t              ent_o,
  output rrip_pkg::entry_t              fwd_o,
  output logic                          match_o
);
  import rrip_pkg::*;

  logic                  vld_q, vld_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [LEVEL_BITS-1:0] lvl_q, lvl_d;

  assign ent_o   = '{vld: vld_q, key: key_q, lvl: lvl_q};
  // raised view of this entry, handed to the older neighbor
  assign fwd_o   = '{vld: vld_q, key: key_q, lvl: lvl_q + ctrl_i.raise};
  assign match_o = vld_q && (key_q == key_i);

  always_comb begin
    if (take_i) begin
      vld_d = prev_i.vld;
      key_d = prev_i.key;
      lvl_d = prev_i.lvl;
    end else begin
      vld_d = fwd_o.vld;
      key_d = fwd_o.key;
      lvl_d = fwd_o.lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.upd) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      key_q <= key_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

// ===== rtl/core/rrip_key_set_with_eviction_out_top.sv =====
// An accepted input enters the busy state and its result is registered on
// leaving it; input stalls while busy or while a held result is stalled.
// One compare-and-shift pass per item; cells in age order, cell 0 newest.
// Reset clears all valid bits and the entry count, and sets capacity to 64.
// Depends on rrip_pkg and rrip_cell.
module rrip_key_set_with_eviction_out_top #(
  parameter int unsigned ENTRIES = rrip_pkg::DEF_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrip_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rrip_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rrip_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [rrip_pkg::KEY_BITS-1:0]   key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [rrip_pkg::LEVEL_BITS-1:0] hit_level_o,
  output logic                            evicted_valid_o,
  output logic [rrip_pkg::KEY_BITS-1:0]   evicted_key_o
);
  import rrip_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int unsigned NLVL  = 1 << LEVEL_BITS;

  typedef enum logic {ST_IDLE, ST_BUSY} state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [CAP_BITS-1:0] cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                cmd_q;
  logic [KEY_BITS-1:0] key_q;

  logic                  hit_q, ev_valid_q;
  logic [LEVEL_BITS-1:0] hit_level_q;
  logic [KEY_BITS-1:0]   ev_key_q;

  logic accept, cfg_wr;

  entry_t ent [ENTRIES];
  entry_t fwd [ENTRIES];
  entry_t head;
  ctrl_t  ctrl;

  logic [ENTRIES-1:0]    match_v, atmax_v, rev_v, iso_v, vic_oh, stop_v, take_v;
  logic [NLVL-1:0]       lvl_any;
  logic [LEVEL_BITS-1:0] maxl, hit_lvl, sel_lvl;
  logic [KEY_BITS-1:0]   vic_key;
  logic                  any_hit, evict_need;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);
  assign prdata = (paddr == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  // ---------------- handshake ----------------
  assign in_stall_o  = (state_q == ST_BUSY) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign hit_o           = hit_q;
  assign hit_level_o     = hit_level_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_key_o   = ev_key_q;

  // ---------------- cell row ----------------
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t prev;
    assign prev = (g == 0) ? head : fwd[(g == 0) ? 0 : g - 1];
    rrip_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .take_i  (take_v[g]),
      .prev_i  (prev),
      .key_i   (key_q),
      .ent_o   (ent[g]),
      .fwd_o   (fwd[g]),
      .match_o (match_v[g])
    );
  end

  // ---------------- reductions over the row ----------------
  always_comb begin
    lvl_any = '0;
    hit_lvl = '0;
    vic_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent[i].vld) lvl_any[ent[i].lvl] = 1'b1;
      hit_lvl = hit_lvl | (ent[i].lvl & {LEVEL_BITS{match_v[i]}});
      vic_key = vic_key | (ent[i].key & {KEY_BITS{vic_oh[i]}});
    end
  end

  always_comb begin
    maxl = '0;
    for (int l = 0; l < NLVL; l++) begin
      if (lvl_any[l]) maxl = LEVEL_BITS'(l);
    end
  end

  // victim: oldest (highest position) entry at the current maximum level
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      atmax_v[i] = ent[i].vld && (ent[i].lvl == maxl);
      rev_v[i]   = atmax_v[ENTRIES-1-i];
    end
    iso_v = rev_v & (~rev_v + 1'b1);
    for (int i = 0; i < ENTRIES; i++) vic_oh[i] = iso_v[ENTRIES-1-i];
  end

  assign any_hit = |match_v;

  always_comb begin
    if (cap_q == '0) begin
      evict_need = (count_q != '0);
    end else begin
      evict_need = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(ENTRIES));
    end
    evict_need = evict_need && (cmd_q == CMD_INSERT) && !any_hit;
  end

  // cells up to and including the stop position shift one step older
  assign stop_v  = any_hit ? match_v : (evict_need ? vic_oh : '0);
  assign take_v  = (stop_v - ENTRIES'(1)) | stop_v;
  assign sel_lvl = any_hit ? '0 : INSERT_LEVEL;
  assign head    = '{vld: 1'b1, key: key_q, lvl: sel_lvl};

  assign ctrl.upd   = (state_q == ST_BUSY) && (any_hit || (cmd_q == CMD_INSERT));
  assign ctrl.raise = evict_need ? (TOP_LEVEL - maxl) : '0;

  always_comb begin
    count_d = count_q;
    if (ctrl.upd && !any_hit && !evict_need) count_d = count_q + 1'b1;
  end

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
    end else begin
      if (cfg_wr) cap_q <= pwdata[CAP_BITS-1:0];
      count_q <= count_d;
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
          if (accept) state_q <= ST_BUSY;
        end
        ST_BUSY: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i;
    end
    if (state_q == ST_BUSY) begin
      hit_q       <= any_hit;
      hit_level_q <= any_hit ? hit_lvl : '0;
      ev_valid_q  <= evict_need;
      ev_key_q    <= evict_need ? vic_key : '0;
    end
  end

`ifndef SYNTH
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_v)) else $error("key present in more than one cell");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES)) else $error("entry count above row size");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY) |=> out_valid_q) else $error("busy cycle gave no result");

  a_evict_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_need |-> $onehot(vic_oh)) else $error("eviction without a single victim");
`endif

endmodule
